// ----- sv/tri_pkg.sv -----
// ----------------------------------------------------------------------------
// tri_pkg: shared types and constants of the trilateration pipeline
// Holds the field widths, the register map and the structs that travel
// between the geometry front end, the numerator stages and the dividers.
// ----------------------------------------------------------------------------
package tri_pkg;

    localparam int POS_W   = 18;
    localparam int HOPS_W  = 6;
    localparam int HOPD_W  = 13;
    localparam int DIFF_W  = 19;
    localparam int RNG_W   = 19;
    localparam int CF_W    = 41;
    localparam int DET_W   = 39;
    localparam int NUM_W   = 61;
    localparam int DEN_W   = 40;
    localparam int QUO_W   = 18;
    localparam int LO_W    = 24;

    localparam logic [HOPD_W-1:0] HOPD_RESET = 13'd3621;
    localparam logic [0:0]        REG_HOPD   = 1'b0;

    // Differences of the beacon coordinates against beacon 0.
    typedef struct packed {
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] e;
    } geo_t;

    // Right-hand sides and determinant of the linear system.
    typedef struct packed {
        logic signed [CF_W-1:0]  c;
        logic signed [CF_W-1:0]  f;
        logic signed [DET_W-1:0] m;
        geo_t                    g;
    } front_t;

    // Unsigned division job for one axis.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             deg;
    } div_in_t;

    // Quotient magnitude with its overflow mark.
    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             ovf;
        logic             neg;
        logic             deg;
    } div_out_t;

endpackage

// ----- sv/three_anchor_trilateration_unit.sv -----
// Throughput: one item per cycle; 4 geometry, 4 numerator, 19 divider stages, 1 output.
// The divider spends one stage per quotient bit after its range check stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads hop_distance with 3621.
// ----------------------------------------------------------------------------
// three_anchor_trilateration_unit: three-beacon position estimator
// Solves the linearised two-equation system by Cramer's rule and gives a
// truncated, saturated estimate per item, with an APB register for hop size.
// ----------------------------------------------------------------------------
module three_anchor_trilateration_unit (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: anchor0_x, anchor0_y, anchor0_hops, anchor1_x,
    // anchor1_y, anchor1_hops, anchor2_x, anchor2_y, anchor2_hops, zero fill.
    input  logic [127:0] s_tdata,
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: est_x, est_y, zero fill.
    output logic [39:0]  m_tdata,
    // m_tuser: degenerate.
    output logic         m_tuser
);
    import tri_pkg::*;

    localparam logic [QUO_W-1:0] POS_MAX_MAG = 18'd131071;
    localparam logic [QUO_W-1:0] NEG_MAX_MAG = 18'd131072;

    logic [HOPD_W-1:0]   hopd_reg;
    logic                en;
    logic                front_valid, numer_valid, divx_valid, divy_valid;
    front_t              front_data;
    div_in_t             jobx, joby;
    div_out_t            resx, resy;
    logic [3*POS_W-1:0]  xs, ys;
    logic [3*HOPS_W-1:0] hops;
    logic                out_valid_reg;
    logic [POS_W-1:0]    estx_reg, esty_reg, estx_next, esty_next;
    logic                deg_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hopd_reg <= HOPD_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_HOPD && paddr[1:0] == 2'b00)
        begin
            hopd_reg <= pwdata[HOPD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'b000) ? {(32-HOPD_W)'(0), hopd_reg} : 32'd0;

    // The pipeline advances whenever the output register is free or taken.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Unpack the beacon fields.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xs[i*POS_W +: POS_W]    = s_tdata[i*42 +: POS_W];
            ys[i*POS_W +: POS_W]    = s_tdata[i*42 + POS_W +: POS_W];
            hops[i*HOPS_W +: HOPS_W] = s_tdata[i*42 + 2*POS_W +: HOPS_W];
        end
    end

    tri_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .hop_distance (hopd_reg),
        .xs           (xs),
        .ys           (ys),
        .hops         (hops),
        .out_valid    (front_valid),
        .out_data     (front_data)
    );

    tri_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (numer_valid),
        .out_x     (jobx),
        .out_y     (joby)
    );

    tri_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (numer_valid),
        .in_data   (jobx),
        .out_valid (divx_valid),
        .out_data  (resx)
    );

    tri_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (numer_valid),
        .in_data   (joby),
        .out_valid (divy_valid),
        .out_data  (resy)
    );

    // Apply sign and saturation to the quotient magnitudes.
    always_comb
    begin
        if (resx.neg)
        begin
            estx_next = (resx.ovf || resx.q > NEG_MAX_MAG) ? NEG_MAX_MAG : POS_W'(-resx.q);
        end
        else
        begin
            estx_next = (resx.ovf || resx.q > POS_MAX_MAG) ? POS_MAX_MAG : resx.q;
        end
        if (resy.neg)
        begin
            esty_next = (resy.ovf || resy.q > NEG_MAX_MAG) ? NEG_MAX_MAG : POS_W'(-resy.q);
        end
        else
        begin
            esty_next = (resy.ovf || resy.q > POS_MAX_MAG) ? POS_MAX_MAG : resy.q;
        end
        if (resx.deg)
        begin
            estx_next = '0;
            esty_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= divx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            estx_reg <= estx_next;
            esty_reg <= esty_next;
            deg_reg  <= resx.deg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, esty_reg, estx_reg};
    assign m_tuser  = deg_reg;

    // A degenerate result carries a zero estimate.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[35:0] == 36'd0))
        else $error("degenerate result with non-zero estimate");

    // While a result waits, no new item is taken.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("item accepted while output stalled");

    // Both dividers run in lock step.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (divx_valid == divy_valid) && (!divx_valid || resx.deg == resy.deg))
        else $error("divider lanes out of step");

endmodule

// ----- sv/tri_front.sv -----
// ----------------------------------------------------------------------------
// tri_front: geometry front end
// Four register stages: ranges and squares, squared ranges and cross
// products, per-beacon constants and determinant, then c and f.
// ----------------------------------------------------------------------------
module tri_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tri_pkg::HOPD_W-1:0]  hop_distance,
    input  logic [3*tri_pkg::POS_W-1:0] xs,
    input  logic [3*tri_pkg::POS_W-1:0] ys,
    input  logic [3*tri_pkg::HOPS_W-1:0] hops,
    output logic                        out_valid,
    output tri_pkg::front_t             out_data
);
    import tri_pkg::*;

    logic [3:0] valid_reg;

    logic        [RNG_W-1:0] r1_reg   [3];
    logic        [34:0]      xsq1_reg [3];
    logic        [34:0]      ysq1_reg [3];
    geo_t                    g1_reg, g2_reg, g3_reg, g4_reg;

    logic        [37:0]      rsq2_reg [3];
    logic        [35:0]      s2_reg   [3];
    logic signed [37:0]      ae2_reg, db2_reg;

    logic signed [39:0]      k3_reg   [3];
    logic signed [DET_W-1:0] m3_reg, m4_reg;

    logic signed [CF_W-1:0]  c4_reg, f4_reg;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Data path stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [POS_W-1:0]   xi, yi;
                logic signed [2*POS_W-1:0] xx, yy;
                xi = xs[i*POS_W +: POS_W];
                yi = ys[i*POS_W +: POS_W];
                xx = xi * xi;
                yy = yi * yi;
                r1_reg[i]   <= RNG_W'(hops[i*HOPS_W +: HOPS_W] * hop_distance);
                xsq1_reg[i] <= xx[34:0];
                ysq1_reg[i] <= yy[34:0];
                rsq2_reg[i] <= 38'(r1_reg[i] * r1_reg[i]);
                s2_reg[i]   <= {1'b0, xsq1_reg[i]} + {1'b0, ysq1_reg[i]};
                k3_reg[i]   <= $signed({2'b00, rsq2_reg[i]}) - $signed({4'b0000, s2_reg[i]});
            end
            g1_reg.a <= DIFF_W'($signed(xs[0 +: POS_W])) - DIFF_W'($signed(xs[POS_W +: POS_W]));
            g1_reg.b <= DIFF_W'($signed(ys[0 +: POS_W])) - DIFF_W'($signed(ys[POS_W +: POS_W]));
            g1_reg.d <= DIFF_W'($signed(xs[0 +: POS_W]))
                      - DIFF_W'($signed(xs[2*POS_W +: POS_W]));
            g1_reg.e <= DIFF_W'($signed(ys[0 +: POS_W]))
                      - DIFF_W'($signed(ys[2*POS_W +: POS_W]));
            ae2_reg  <= g1_reg.a * g1_reg.e;
            db2_reg  <= g1_reg.d * g1_reg.b;
            m3_reg   <= DET_W'(ae2_reg) - DET_W'(db2_reg);
            c4_reg   <= CF_W'(k3_reg[1]) - CF_W'(k3_reg[0]);
            f4_reg   <= CF_W'(k3_reg[2]) - CF_W'(k3_reg[0]);
            m4_reg   <= m3_reg;
            g2_reg   <= g1_reg;
            g3_reg   <= g2_reg;
            g4_reg   <= g3_reg;
        end
    end

    assign out_valid  = valid_reg[3];
    assign out_data.c = c4_reg;
    assign out_data.f = f4_reg;
    assign out_data.m = m4_reg;
    assign out_data.g = g4_reg;

endmodule

// ----- sv/tri_numer.sv -----
// ----------------------------------------------------------------------------
// tri_numer: Cramer numerators
// Four register stages: split partial products, recombined products,
// numerator differences, then magnitudes, signs and the doubled divisor.
// ----------------------------------------------------------------------------
module tri_numer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tri_pkg::front_t   in_data,
    output logic              out_valid,
    output tri_pkg::div_in_t  out_x,
    output tri_pkg::div_in_t  out_y
);
    import tri_pkg::*;

    localparam int HI_W = CF_W - LO_W;

    logic [3:0] valid_reg;

    // Partial products: index 0 c*e, 1 b*f, 2 a*f, 3 d*c.
    logic signed [LO_W+DIFF_W:0]   plo_reg [4];
    logic signed [HI_W+DIFF_W-1:0] phi_reg [4];
    logic signed [NUM_W-1:0]       prod_reg [4];
    logic signed [NUM_W-1:0]       nx_reg, ny_reg;
    logic signed [DET_W-1:0]       m5_reg, m6_reg, m7_reg;
    div_in_t                       x8_reg, y8_reg;

    logic signed [CF_W-1:0]   mul_a [4];
    logic signed [DIFF_W-1:0] mul_b [4];

    always_comb
    begin
        mul_a[0] = in_data.c;  mul_b[0] = in_data.g.e;
        mul_a[1] = in_data.f;  mul_b[1] = in_data.g.b;
        mul_a[2] = in_data.f;  mul_b[2] = in_data.g.a;
        mul_a[3] = in_data.c;  mul_b[3] = in_data.g.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                plo_reg[i]  <= $signed({1'b0, mul_a[i][LO_W-1:0]}) * mul_b[i];
                phi_reg[i]  <= $signed(mul_a[i][CF_W-1:LO_W]) * mul_b[i];
                prod_reg[i] <= $signed({(NUM_W-LO_W)'(phi_reg[i]), LO_W'(0)})
                             + NUM_W'(plo_reg[i]);
            end
            m5_reg <= in_data.m;
            m6_reg <= m5_reg;
            nx_reg <= prod_reg[0] - prod_reg[1];
            ny_reg <= prod_reg[2] - prod_reg[3];
            m7_reg <= m6_reg;
            // Magnitudes for the unsigned dividers, signs kept aside.
            x8_reg.num <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            y8_reg.num <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            x8_reg.den <= {(m7_reg[DET_W-1] ? DET_W'(-m7_reg) : DET_W'(m7_reg)), 1'b0};
            y8_reg.den <= {(m7_reg[DET_W-1] ? DET_W'(-m7_reg) : DET_W'(m7_reg)), 1'b0};
            x8_reg.neg <= nx_reg[NUM_W-1] ^ m7_reg[DET_W-1];
            y8_reg.neg <= ny_reg[NUM_W-1] ^ m7_reg[DET_W-1];
            x8_reg.deg <= (m7_reg == '0);
            y8_reg.deg <= (m7_reg == '0);
        end
    end

    assign out_valid = valid_reg[3];
    assign out_x     = x8_reg;
    assign out_y     = y8_reg;

endmodule

// ----- sv/tri_div.sv -----
// ----------------------------------------------------------------------------
// tri_div: pipelined restoring divider
// One stage checks for a quotient beyond the position range, then one
// stage per quotient bit subtracts the shifted divisor where it fits.
// ----------------------------------------------------------------------------
module tri_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tri_pkg::div_in_t  in_data,
    output logic              out_valid,
    output tri_pkg::div_out_t out_data
);
    import tri_pkg::*;

    localparam int STAGES = QUO_W + 1;

    logic [STAGES-1:0] valid_reg;
    logic [NUM_W-1:0]  rem_reg [STAGES];
    logic [DEN_W-1:0]  den_reg [STAGES];
    logic [QUO_W-1:0]  q_reg   [STAGES];
    logic              ovf_reg [STAGES];
    logic              neg_reg [STAGES];
    logic              deg_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Overflow check: quotient of 2^18 or more saturates anyway.
            rem_reg[0] <= in_data.num;
            den_reg[0] <= in_data.den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (in_data.num >= ({(NUM_W-DEN_W)'(0), in_data.den} << QUO_W));
            neg_reg[0] <= in_data.neg;
            deg_reg[0] <= in_data.deg;
            // One quotient bit per stage, most significant first.
            for (int k = 1; k < STAGES; k++)
            begin
                logic [NUM_W-1:0] sh;
                logic [NUM_W:0]   trial;
                logic [QUO_W-1:0] qn;
                sh    = {(NUM_W-DEN_W)'(0), den_reg[k-1]} << (QUO_W - k);
                trial = {1'b0, rem_reg[k-1]} - {1'b0, sh};
                qn    = q_reg[k-1];
                qn[QUO_W-k] = ~trial[NUM_W];
                rem_reg[k] <= trial[NUM_W] ? rem_reg[k-1] : trial[NUM_W-1:0];
                q_reg[k]   <= qn;
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    assign out_valid    = valid_reg[STAGES-1];
    assign out_data.q   = q_reg[STAGES-1];
    assign out_data.ovf = ovf_reg[STAGES-1];
    assign out_data.neg = neg_reg[STAGES-1];
    assign out_data.deg = deg_reg[STAGES-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-anchor trilateration unit
// Drives beacon triples on the input stream with random gaps, predicts each
// position estimate exactly in wide integers, and checks every result item in
// order while the output side stalls at random. hop_distance is changed over
// APB between phases, including its extremes.
// ----------------------------------------------------------------------------
import tri_pkg::*;

// Position estimate expected for one accepted item.
typedef struct {
    logic signed [POS_W-1:0] est_x;
    logic signed [POS_W-1:0] est_y;
    logic                    degenerate;
} estimate_t;

class estimate_board;
    estimate_t   pending[$];
    logic [HOPD_W-1:0] hop_dist;
    int          errors;

    function new();
        hop_dist = HOPD_RESET;
        errors   = 0;
    endfunction

    // Saturate a quotient to the position range.
    function logic signed [POS_W-1:0] clamp(input logic signed [127:0] v);
        if (v > 131071)
            return 18'sd131071;
        if (v < -131072)
            return -18'sd131072;
        return v[POS_W-1:0];
    endfunction

    // Work out the estimate for one beacon triple and queue it.
    function void note_item(input logic [127:0] data);
        logic signed [127:0] px[3], py[3], kk[3], rr;
        logic signed [127:0] a, b, d, e, c, f, m, den, nx, ny;
        estimate_t r;
        for (int i = 0; i < 3; i++)
        begin
            px[i] = $signed(data[i*42 +: 18]);
            py[i] = $signed(data[i*42+18 +: 18]);
            rr    = $signed({1'b0, data[i*42+36 +: 6]}) * $signed({1'b0, hop_dist});
            kk[i] = rr * rr - px[i] * px[i] - py[i] * py[i];
        end
        a = px[0] - px[1];
        b = py[0] - py[1];
        d = px[0] - px[2];
        e = py[0] - py[2];
        c = kk[1] - kk[0];
        f = kk[2] - kk[0];
        m = a * e - d * b;
        if (m == 0)
        begin
            r.est_x = '0;
            r.est_y = '0;
            r.degenerate = 1'b1;
        end
        else
        begin
            den = 2 * m;
            nx  = c * e - b * f;
            ny  = a * f - d * c;
            r.est_x = clamp(nx / den);
            r.est_y = clamp(ny / den);
            r.degenerate = 1'b0;
        end
        pending = {pending, r};
    endfunction

    task report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // Compare one result item against the oldest expectation.
    task check_result(input logic [39:0] data, input logic deg);
        estimate_t r;
        if (pending.size() == 0)
        begin
            report("result item with nothing expected");
            return;
        end
        r = pending.pop_front();
        if (data[17:0] !== r.est_x)
            report($sformatf("est_x got %0d want %0d", $signed(data[17:0]), r.est_x));
        if (data[35:18] !== r.est_y)
            report($sformatf("est_y got %0d want %0d", $signed(data[35:18]), r.est_y));
        if (deg !== r.degenerate)
            report($sformatf("degenerate got %0b want %0b", deg, r.degenerate));
    endtask
endclass

module tb_top;
    logic         clk;
    logic         rst_n;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;

    estimate_board board;

    three_anchor_trilateration_unit uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Build one item from three beacons.
    function automatic logic [127:0] pack_item(input logic [17:0] x0, y0, input logic [5:0] h0,
                                               input logic [17:0] x1, y1, input logic [5:0] h1,
                                               input logic [17:0] x2, y2, input logic [5:0] h2);
        return {2'b0, h2, y2, x2, h1, y1, x1, h0, y0, x0};
    endfunction

    // Random coordinate: mostly small, sometimes full range.
    function automatic logic [17:0] rand_pos();
        case ($urandom_range(3))
            0: return 18'($urandom);
            1: return $urandom_range(1) ? 18'(18'h1FFFF - $urandom_range(15))
                                        : 18'(18'h20000 + $urandom_range(15));
            default: return 18'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0)
            board.hop_dist = value[HOPD_W-1:0];
    endtask

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(input logic [127:0] data);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        board.note_item(data);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_items(input int count, input bit collinear);
        logic [17:0] x0, y0, x1, y1, x2, y2;
        for (int n = 0; n < count; n++)
        begin
            x0 = rand_pos(); y0 = rand_pos(); x1 = rand_pos(); y1 = rand_pos();
            if (collinear && $urandom_range(4) == 0)
            begin
                x2 = 18'(x0 + 2 * (x1 - x0));
                y2 = 18'(y0 + 2 * (y1 - y0));
            end
            else
            begin
                x2 = rand_pos(); y2 = rand_pos();
            end
            send_item(pack_item(x0, y0, 6'($urandom), x1, y1, 6'($urandom),
                                x2, y2, 6'($urandom)));
        end
    endtask

    // Receiver with random stalls; results are checked at the rising edge.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(2) == 0 ? 0 : $urandom_range(19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        #5000000;
        $display("FAIL three_anchor_trilateration_unit");
        $finish;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset hop distance, extremes, zero hops, collinear beacons.
        send_item(pack_item(18'd0, 18'd0, 6'd3, 18'd1000, 18'd0, 6'd2, 18'd0, 18'd1000, 6'd2));
        send_item(pack_item(18'h1FFFF, 18'h1FFFF, 6'd63, 18'h20000, 18'h1FFFF, 6'd63,
                            18'h1FFFF, 18'h20000, 6'd0));
        send_item(pack_item(18'h20000, 18'h20000, 6'd0, 18'h1FFFF, 18'h20000, 6'd0,
                            18'h20000, 18'h1FFFF, 6'd0));
        send_item(pack_item(18'd0, 18'd0, 6'd1, 18'd5, 18'd5, 6'd1, 18'd10, 18'd10, 6'd1));
        send_item(pack_item(18'd7, 18'd7, 6'd4, 18'd7, 18'd7, 6'd4, 18'd7, 18'd7, 6'd4));
        send_item(pack_item(18'd0, 18'd0, 6'd63, 18'd1, 18'd0, 6'd0, 18'd0, 18'd1, 6'd0));
        send_item(pack_item(18'h3FFFF, 18'd0, 6'd0, 18'd0, 18'h3FFFF, 6'd63, 18'd1, 18'd1, 6'd32));
        random_items(8, 1'b1);
        wait_drained();

        // Phases over several hop distances, extremes included.
        apb_write(3'd0, 32'd0);
        random_items(100, 1'b1);
        wait_drained();
        apb_write(3'd0, 32'd8191);
        random_items(130, 1'b1);
        wait_drained();
        apb_write(3'd4, 32'd17);
        apb_write(3'd0, 32'd1);
        random_items(100, 1'b1);
        wait_drained();
        apb_write(3'd0, 32'hFFFF_E000 | $urandom_range(8191));
        random_items(150, 1'b1);
        wait_drained();
        apb_write(3'd0, 32'd3621);
        random_items(150, 1'b1);
        wait_drained();

        if (board.errors == 0)
            $display("PASS three_anchor_trilateration_unit");
        else
            $display("FAIL three_anchor_trilateration_unit");
        $finish;
    end
endmodule
